// ===== design/hxd_pkg.sv =====
package hxd_pkg;

  localparam logic [7:0] ESC_CHAR = 8'h5C;
  localparam logic [7:0] X_CHAR   = 8'h78;

  // default depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;

  // one run of decoded bytes caused by one input word
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte of the run
    logic            msg_end;   // run closes the message
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic res;
    res = ((c >= 8'h30) && (c <= 8'h39)) ||
          ((c >= 8'h41) && (c <= 8'h46)) ||
          ((c >= 8'h61) && (c <= 8'h66));
    return res;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      diff = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      diff = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      diff = c - 8'h57;
    end else begin
      diff = 8'h00;
    end
    return diff[3:0];
  endfunction

endpackage

// ===== design/hxd_front.sv =====
module hxd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            in_end,
  output logic            push,
  output hxd_pkg::run_t   entry,
  input  logic            full
);
  import hxd_pkg::*;

  // pending group is always a prefix of backslash, x, hex digit;
  // only the held hex digit needs storage
  logic [1:0] pend_cnt;
  logic [1:0] pend_cnt_next;
  logic [7:0] pend_hex;
  logic       ext_ok;
  logic       hold;
  logic       accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (pend_cnt)
      2'd0: ext_ok = (in_char == ESC_CHAR);
      2'd1: ext_ok = (in_char == X_CHAR);
      default: ext_ok = is_hex(in_char);
    endcase
  end

  always_comb begin
    hold            = (in_char == ESC_CHAR) && !in_end;
    entry.msg_end   = in_end;
    entry.bytes[0]  = (pend_cnt == 2'd0) ? in_char : ESC_CHAR;
    entry.bytes[1]  = (pend_cnt == 2'd1) ? in_char : X_CHAR;
    entry.bytes[2]  = (pend_cnt == 2'd2) ? in_char : pend_hex;
    entry.bytes[3]  = in_char;
    entry.last_idx  = 2'd0;
    push            = 1'b0;
    pend_cnt_next   = pend_cnt;
    if ((pend_cnt == 2'd3) && ext_ok) begin
      // group complete: one decoded byte
      entry.bytes[0] = {hex_value(pend_hex), hex_value(in_char)};
      push           = accept;
      pend_cnt_next  = 2'd0;
    end else if (ext_ok && !in_end) begin
      pend_cnt_next = pend_cnt + 2'd1;
    end else begin
      // broken group or end flush: held chars go out literally,
      // a new backslash opens a fresh group
      push           = accept && !(hold && (pend_cnt == 2'd0));
      entry.last_idx = hold ? (pend_cnt - 2'd1) : pend_cnt;
      pend_cnt_next  = hold ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      pend_cnt <= pend_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pend_cnt == 2'd2)) begin
      pend_hex <= in_char;
    end
  end

endmodule

// ===== design/hxd_fifo.sv =====
module hxd_fifo #(
  parameter int DEPTH = hxd_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hxd_pkg::run_t  wr_data,
  output logic           full,
  input  logic           pop,
  output hxd_pkg::run_t  rd_data,
  output logic           not_empty
);
  import hxd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/hxd_back.sv =====
module hxd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  hxd_pkg::run_t  head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic [0:0]     m_tuser
);
  import hxd_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !m_tvalid || m_tready;
  assign at_last = (idx == head.last_idx);
  assign pop     = load && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      m_tdata    <= head.bytes[idx];
      m_tuser[0] <= at_last;
      m_tlast    <= at_last && head.msg_end;
    end
  end

endmodule

// ===== design/hex_escape_decoder.sv =====
// hex escape decoder: turns a character stream, one word per cycle, into
// bytes where each group of backslash, x and two hex digits (either case)
// becomes the byte it names and every other character passes unchanged.
// the front accepts a character every cycle while the run queue has room,
// holding up to three characters of a possible group; each input yields
// zero to four output words, which the back hands out one per cycle unless
// m_tready stalls it, so throughput is one output word per cycle and one
// input per cycle as long as inputs average at most one output each. the
// first output word passes the run queue and the output register. s_tlast
// closes a message and flushes held chars literally unless it completes a
// group; the message's final word carries m_tlast. a zero char is ordinary data.
module hex_escape_decoder #(
  parameter int FIFO_DEPTH = hxd_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,   // in_end
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // msg_last
  output logic [0:0] m_tuser    // [0] run_last
);
  import hxd_pkg::*;

  // front to queue
  logic push;
  run_t push_entry;
  logic full;
  // queue to back
  logic pop;
  run_t head;
  logic head_valid;

  // classify and collect each input word into a run of up to four bytes
  hxd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .in_end   (s_tlast),
    .push     (push),
    .entry    (push_entry),
    .full     (full)
  );

  // short run queue decouples input stalls from output stalls
  hxd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (push_entry),
    .full      (full),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (head_valid)
  );

  // serialize each run into the output register
  hxd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

`ifndef SYNTHESIS
  // end of message is always the end of a run
  a_tlast_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("message end without run end");

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("run queue overflow");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("run queue underflow");

  // output idle right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
